### sv/dcl_pkg.sv
// ----------------------------------------------------------------------------
// dcl_pkg
// Shared types and constants for the DC load setpoint and meter block.
// ----------------------------------------------------------------------------
package dcl_pkg;

    typedef enum logic [1:0] {
        MODE_CC,
        MODE_CV,
        MODE_CP,
        MODE_CR
    } t_mode;

    localparam logic CFG_LOAD_MODE = 1'b0;
    localparam logic CFG_TARGET    = 1'b1;

    localparam logic [6:0]  VOLT_MUL  = 7'd122;
    localparam logic [6:0]  VOLT_DIV  = 7'd100;
    localparam logic [12:0] AMP_MUL   = 13'd7326;
    localparam logic [13:0] AMP_DIV   = 14'd10000;
    localparam logic [9:0]  SCALE_K   = 10'd1000;
    localparam logic [11:0] DAC_FULL  = 12'd4095;
    localparam logic [8:0]  AMP_FULL  = 9'd500;
    localparam logic [13:0] FRAME_CMD = 14'h3000;
    localparam logic [12:0] OHMS_MAX  = 13'd4999;

    // floor(2^32 / d) reciprocals
    localparam int unsigned REC_SHIFT = 32;
    localparam logic [25:0] REC_100   = 26'd42949672;
    localparam logic [18:0] REC_10000 = 19'd429496;
    localparam logic [22:0] REC_1000  = 23'd4294967;
    localparam logic [23:0] REC_500   = 24'd8589934;

    typedef struct packed {
        logic [11:0] vs;
        logic [11:0] cs;
        t_mode       mode;
        logic [13:0] target;
    } t_item;

endpackage

### sv/dcl_front.sv
// ----------------------------------------------------------------------------
// dcl_front
// Holds the configuration registers and tags each sample request for the queue.
// ----------------------------------------------------------------------------
module dcl_front
    import dcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_voltage_sample,
    input  logic [11:0] i_current_sample,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    t_mode       r_mode;
    logic [13:0] r_target;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && !i_q_full;

    always_comb begin
        o_item.vs     = i_voltage_sample;
        o_item.cs     = i_current_sample;
        o_item.mode   = r_mode;
        o_item.target = r_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_CC;
            r_target <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOAD_MODE: r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_TARGET:    r_target <= i_cfg_data;
                default:       r_target <= r_target;
            endcase
        end
    end

endmodule

### sv/dcl_queue.sv
// ----------------------------------------------------------------------------
// dcl_queue
// Small FIFO of sample requests between the front and back parts.
// ----------------------------------------------------------------------------
module dcl_queue
    import dcl_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### sv/dcl_div.sv
// ----------------------------------------------------------------------------
// dcl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcl_div #(
    parameter int NW = 24,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [NW-1:0] o_quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_trial    = {r_rem, r_quo[NW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign w_diff     = w_trial - {1'b0, r_dvs};
    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

endmodule

### sv/dcl_back.sv
// ----------------------------------------------------------------------------
// dcl_back
// Scales samples, forms power, resistance and DAC code, holds the result.
// ----------------------------------------------------------------------------
module dcl_back
    import dcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_dac_code,
    output logic        o_dac_write,
    output logic [13:0] o_spi_frame,
    output logic [12:0] o_volts_scaled,
    output logic [11:0] o_amps_scaled,
    output logic [13:0] o_power_scaled,
    output logic [12:0] o_ohms_value,
    output logic        o_ohms_over
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SREC, ST_SFIX, ST_START, ST_PREC, ST_PFIX,
        ST_WAIT, ST_CMUL, ST_CREC, ST_CFIX, ST_DONE
    } t_state;

    t_state      r_state;
    t_mode       r_mode;
    logic [13:0] r_target;
    logic [18:0] r_p;
    logic [24:0] r_a;
    logic [12:0] r_qv;
    logic [11:0] r_qa;
    logic [12:0] r_volts;
    logic [11:0] r_amps;
    logic [23:0] r_pw;
    logic [13:0] r_pq;
    logic [13:0] r_power;
    logic [20:0] r_x;
    logic        r_ok;
    logic [11:0] r_cq;
    logic [11:0] r_code;
    logic [12:0] r_ohms;
    logic        r_over;
    logic        r_valid;

    logic [44:0] w_pv;
    logic [43:0] w_pa;
    logic [18:0] w_vm;
    logic [24:0] w_am;
    logic        w_vinc;
    logic        w_ainc;
    logic [46:0] w_pp;
    logic [23:0] w_pm;
    logic        w_pinc;
    logic [44:0] w_pc;
    logic [20:0] w_cm;
    logic        w_cinc;
    logic [23:0] w_q;
    logic        w_ok;
    logic        w_fit;
    logic        w_start;
    logic [23:0] w_mdnd;
    logic [13:0] w_mdvs;
    logic        w_obusy;
    logic        w_mbusy;
    logic [12:0] w_oq;
    logic [23:0] w_mq;
    logic        w_load;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign w_start = (r_state == ST_START);
    assign w_load  = (r_state == ST_DONE) && (!r_valid || i_ready);

    assign w_pv   = r_p * REC_100;
    assign w_pa   = r_a * REC_10000;
    assign w_vm   = r_qv * VOLT_DIV;
    assign w_am   = r_qa * AMP_DIV;
    assign w_vinc = ((r_p - w_vm) >= 19'(VOLT_DIV));
    assign w_ainc = ((r_a - w_am) >= 25'(AMP_DIV));
    assign w_pp   = r_pw * REC_1000;
    assign w_pm   = r_pq * SCALE_K;
    assign w_pinc = ((r_pw - w_pm) >= 24'(SCALE_K));
    assign w_pc   = r_x * REC_500;
    assign w_cm   = r_cq * AMP_FULL;
    assign w_cinc = ((r_x - w_cm) >= 21'(AMP_FULL));

    always_comb begin
        if (r_mode == MODE_CP) begin
            w_mdnd = r_target * SCALE_K;
            w_mdvs = {1'b0, r_volts};
        end else begin
            w_mdnd = r_volts * SCALE_K;
            w_mdvs = r_target;
        end
    end

    always_comb begin
        case (r_mode)
            MODE_CC: begin
                w_q  = {10'd0, r_target};
                w_ok = 1'b1;
            end
            MODE_CV: begin
                w_q  = '0;
                w_ok = 1'b1;
            end
            MODE_CP: begin
                w_q  = w_mq;
                w_ok = (r_volts != '0);
            end
            default: begin
                w_q  = w_mq;
                w_ok = (r_target != '0);
            end
        endcase
        w_fit = w_ok && (w_q <= 24'(AMP_FULL));
    end

    dcl_div #(.NW(13), .DW(12)) u_ohms_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_volts),
        .i_divisor  (r_amps),
        .o_busy     (w_obusy),
        .o_quotient (w_oq)
    );

    dcl_div #(.NW(24), .DW(14)) u_mode_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_mdnd),
        .i_divisor  (w_mdvs),
        .o_busy     (w_mbusy),
        .o_quotient (w_mq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_SREC;
                    end
                end
                ST_SREC:  r_state <= ST_SFIX;
                ST_SFIX:  r_state <= ST_START;
                ST_START: r_state <= ST_PREC;
                ST_PREC:  r_state <= ST_PFIX;
                ST_PFIX:  r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (!w_obusy && !w_mbusy) begin
                        r_state <= ST_CMUL;
                    end
                end
                ST_CMUL:  r_state <= ST_CREC;
                ST_CREC:  r_state <= ST_CFIX;
                ST_CFIX:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
        if (o_pop) begin
            r_mode   <= i_head.mode;
            r_target <= i_head.target;
            r_p      <= i_head.vs * VOLT_MUL;
            r_a      <= i_head.cs * AMP_MUL;
        end
        if (r_state == ST_SREC) begin
            r_qv <= w_pv[44:32];
            r_qa <= w_pa[43:32];
        end
        if (r_state == ST_SFIX) begin
            r_volts <= r_qv + {12'd0, w_vinc};
            r_amps  <= r_qa + {11'd0, w_ainc};
        end
        if (r_state == ST_START) begin
            r_pw <= r_volts * r_amps;
        end
        if (r_state == ST_PREC) begin
            r_pq <= w_pp[45:32];
        end
        if (r_state == ST_PFIX) begin
            r_power <= r_pq + {13'd0, w_pinc};
        end
        if (r_state == ST_CMUL) begin
            r_ok   <= w_fit;
            r_x    <= w_fit ? w_q[8:0] * DAC_FULL : '0;
            r_over <= (r_amps == '0) || (w_oq > OHMS_MAX);
            r_ohms <= ((r_amps == '0) || (w_oq > OHMS_MAX)) ? '0 : w_oq;
        end
        if (r_state == ST_CREC) begin
            r_cq <= w_pc[43:32];
        end
        if (r_state == ST_CFIX) begin
            r_code <= r_cq + {11'd0, w_cinc};
        end
        if (w_load) begin
            o_dac_code     <= r_ok ? r_code : '0;
            o_dac_write    <= r_ok;
            o_spi_frame    <= r_ok ? (FRAME_CMD | {2'b00, r_code}) : '0;
            o_volts_scaled <= r_volts;
            o_amps_scaled  <= r_amps;
            o_power_scaled <= r_power;
            o_ohms_value   <= r_ohms;
            o_ohms_over    <= r_over;
        end
    end

endmodule

### sv/dc_load_setpoint_and_meter.sv
// ----------------------------------------------------------------------------
// dc_load_setpoint_and_meter
// Meters load voltage, current, power and resistance and forms the DAC code.
//
//   channel  handshake                 payload
//   cfg      i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//   sample   i_valid/o_ready           i_voltage_sample, i_current_sample
//   result   o_valid/i_ready           o_dac_code ... o_ohms_over
//
// In the back part each sample waits on the 24-step setpoint divider; the
// resistance divider runs beside it. A result that waits holds the back part
// in its last state. The queue takes new samples while the back part works
// or a result waits, until the queue is full.
// Reset clears the configuration registers to constant current, setpoint 0.
// ----------------------------------------------------------------------------
module dc_load_setpoint_and_meter
    import dcl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_voltage_sample,
    input  logic [11:0] i_current_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_dac_code,
    output logic        o_dac_write,
    output logic [13:0] o_spi_frame,
    output logic [12:0] o_volts_scaled,
    output logic [11:0] o_amps_scaled,
    output logic [13:0] o_power_scaled,
    output logic [12:0] o_ohms_value,
    output logic        o_ohms_over
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_item w_item;
    t_item w_head;

    dcl_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_voltage_sample (i_voltage_sample),
        .i_current_sample (i_current_sample),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_item           (w_item)
    );

    dcl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    dcl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_dac_code     (o_dac_code),
        .o_dac_write    (o_dac_write),
        .o_spi_frame    (o_spi_frame),
        .o_volts_scaled (o_volts_scaled),
        .o_amps_scaled  (o_amps_scaled),
        .o_power_scaled (o_power_scaled),
        .o_ohms_value   (o_ohms_value),
        .o_ohms_over    (o_ohms_over)
    );

endmodule

### tb/dc_load_setpoint_and_meter_tb.sv
// ----------------------------------------------------------------------------
// dc_load_setpoint_and_meter_tb
// Drives sample pairs through the meter under several load modes and
// setpoints, predicts scaled readings and DAC codes, and checks each result.
// ----------------------------------------------------------------------------
module dc_load_setpoint_and_meter_tb;
    import dcl_pkg::*;

    typedef struct {
        logic [11:0] dac_code;
        logic        dac_write;
        logic [13:0] spi_frame;
        logic [12:0] volts;
        logic [11:0] amps;
        logic [13:0] power;
        logic [12:0] ohms;
        logic        over;
    } t_reading;

    typedef struct {
        logic [11:0] vs;
        logic [11:0] cs;
        bit          has_fixed;
        t_reading    fixed;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_LOAD_MODE;
    logic [13:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [11:0] i_voltage_sample = '0;
    logic [11:0] i_current_sample = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_dac_code;
    logic        o_dac_write;
    logic [13:0] o_spi_frame;
    logic [12:0] o_volts_scaled;
    logic [11:0] o_amps_scaled;
    logic [13:0] o_power_scaled;
    logic [12:0] o_ohms_value;
    logic        o_ohms_over;

    t_mode       mode_reg = MODE_CC;
    logic [13:0] target_reg = '0;
    t_reading    pending_readings[$];
    int          mismatches = 0;
    int          table_errors = 0;
    int          cycles = 0;
    int          hold_off = 0;
    bit          stall_req = 1'b0;
    bit          stall_seen = 1'b0;
    bit          done = 1'b0;

    dc_load_setpoint_and_meter dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_reading predict_reading(logic [11:0] vs, logic [11:0] cs);
        t_reading r;
        longint unsigned v, a, q, code;
        bit ok;
        v = longint'(vs) * 122 / 100;
        a = longint'(cs) * 7326 / 10000;
        ok = 1;
        code = 0;
        r.volts = 13'(v);
        r.amps = 12'(a);
        r.power = 14'(v * a / 1000);
        r.ohms = '0;
        r.over = 1'b1;
        if (a != 0 && v / a <= 4999) begin
            r.ohms = 13'(v / a);
            r.over = 1'b0;
        end
        case (mode_reg)
            MODE_CC: code = longint'(target_reg) * 4095 / 500;
            MODE_CV: code = 0;
            MODE_CP: begin
                if (v == 0) ok = 0;
                else code = (longint'(target_reg) * 1000 / v) * 4095 / 500;
            end
            default: begin
                if (target_reg == 0) ok = 0;
                else code = (v * 1000 / target_reg) * 4095 / 500;
            end
        endcase
        if (ok && code > 4095) ok = 0;
        if (!ok) code = 0;
        r.dac_code = 12'(code);
        r.dac_write = ok;
        r.spi_frame = ok ? (FRAME_CMD | 14'(code)) : '0;
        return r;
    endfunction

    task automatic write_reg(logic idx, logic [13:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LOAD_MODE) mode_reg = t_mode'(data[1:0]);
        else target_reg = data;
    endtask

    task automatic drain();
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_mode(t_mode m, logic [13:0] t);
        i_valid <= 1'b0;
        drain();
        write_reg(CFG_LOAD_MODE, 14'(m));
        write_reg(CFG_TARGET, t);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [11:0] vs, logic [11:0] cs, bit gaps);
        int g;
        if (gaps && $urandom_range(0, 3) == 0) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_voltage_sample <= vs;
        i_current_sample <= cs;
        do @(posedge i_clk); while (!o_ready);
        pending_readings.push_back(predict_reading(vs, cs));
    endtask

    task automatic send_row(t_row row);
        if (row.has_fixed) begin
            if (predict_reading(row.vs, row.cs) != row.fixed) begin
                table_errors++;
                $display("table row mismatch vs=%0d cs=%0d", row.vs, row.cs);
            end
        end
        send_sample(row.vs, row.cs, 1'b0);
    endtask

    function automatic t_reading fixed_reading(int code, bit wr, int v, int a, int p,
                                               int o, bit ov);
        t_reading r;
        r.dac_code = 12'(code);
        r.dac_write = wr;
        r.spi_frame = wr ? (FRAME_CMD | 14'(code)) : '0;
        r.volts = 13'(v);
        r.amps = 12'(a);
        r.power = 14'(p);
        r.ohms = 13'(o);
        r.over = ov;
        return r;
    endfunction

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (stall_req && !stall_seen) begin
            stall_seen <= 1'b1;
            hold_off <= 400;
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else if (!done) begin
            i_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reading got, want;
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got.dac_code = o_dac_code;
            got.dac_write = o_dac_write;
            got.spi_frame = o_spi_frame;
            got.volts = o_volts_scaled;
            got.amps = o_amps_scaled;
            got.power = o_power_scaled;
            got.ohms = o_ohms_value;
            got.over = o_ohms_over;
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_readings.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_mode m;
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: constant current, setpoint 0
        rows.push_back('{12'd0, 12'd0, 1, fixed_reading(0, 1, 0, 0, 0, 0, 1)});
        rows.push_back('{12'd4095, 12'd4095, 1,
                         fixed_reading(0, 1, 4995, 2999, 14980, 1, 0)});
        rows.push_back('{12'd4095, 12'd0, 1, fixed_reading(0, 1, 4995, 0, 0, 0, 1)});
        rows.push_back('{12'd0, 12'd4095, 1, fixed_reading(0, 1, 0, 2999, 0, 0, 0)});
        rows.push_back('{12'd4095, 12'd2, 1, fixed_reading(0, 1, 4995, 1, 4, 4995, 0)});
        rows.push_back('{12'd4095, 12'd1, 1, fixed_reading(0, 1, 4995, 0, 0, 0, 1)});
        rows.push_back('{12'd2730, 12'd1365, 0, fixed_reading(0, 0, 0, 0, 0, 0, 0)});
        foreach (rows[i]) send_row(rows[i]);

        set_mode(MODE_CC, 14'd500);
        send_sample(12'd100, 12'd100, 0);
        set_mode(MODE_CC, 14'd501);
        send_sample(12'd100, 12'd100, 0);
        set_mode(MODE_CC, 14'h3FFF);
        send_sample(12'd100, 12'd100, 0);
        set_mode(MODE_CV, 14'd1234);
        send_sample(12'd4095, 12'd4095, 0);
        set_mode(MODE_CP, 14'd100);
        send_sample(12'd0, 12'd100, 0);
        send_sample(12'd4095, 12'd100, 0);
        send_sample(12'd1, 12'd100, 0);
        set_mode(MODE_CR, 14'd0);
        send_sample(12'd2000, 12'd100, 0);
        set_mode(MODE_CR, 14'd9999);
        send_sample(12'd4095, 12'd3000, 0);
        send_sample(12'd0, 12'd3000, 0);
        set_mode(MODE_CR, 14'd1);
        send_sample(12'd1, 12'd1, 0);
        send_sample(12'd4095, 12'd1, 0);

        for (int phase = 0; phase < 12; phase++) begin
            m = t_mode'(phase % 4);
            case ($urandom_range(0, 5))
                0: set_mode(m, 14'd0);
                1: set_mode(m, 14'h3FFF);
                2: set_mode(m, 14'(9999));
                default: set_mode(m, 14'($urandom_range(0, 2000)));
            endcase
            if (phase == 3) stall_req = 1'b1;
            for (k = 0; k < 58; k++) begin
                case ($urandom_range(0, 7))
                    0: send_sample(12'($urandom_range(0, 3)), 12'($urandom), 1);
                    1: send_sample(12'($urandom), 12'($urandom_range(0, 3)), 1);
                    2: send_sample(12'hFFF - 12'($urandom_range(0, 3)), 12'($urandom), 1);
                    default: send_sample(12'($urandom), 12'($urandom), 1);
                endcase
            end
            if (phase == 6) begin
                i_valid <= 1'b0;
                drain();
            end
        end

        i_valid <= 1'b0;
        done = 1'b1;
        drain();
        if (mismatches == 0 && table_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
